// ----- hdl/osdab_pkg.sv -----
`timescale 1ns / 1ps

package osdab_pkg;

  localparam int unsigned PixelWidth = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned ChanWidth  = 6;

  localparam logic [ChanWidth-1:0] CH5_MAX = 6'h1F;
  localparam logic [ChanWidth-1:0] CH6_MAX = 6'h3F;

  typedef logic [PixelWidth-1:0] pixel_t;
  typedef logic [ByteWidth-1:0]  byte_t;
  typedef logic [ChanWidth-1:0]  chan_t;

  typedef enum logic {
    REG_PIXEL_FORMAT = 1'b0,
    REG_FAST_MODE    = 1'b1
  } reg_index_t;

  typedef enum logic {
    FMT_RGB555 = 1'b0,
    FMT_RGB565 = 1'b1
  } pixel_format_t;

  typedef struct packed {
    pixel_format_t pixel_format;
    logic          fast_mode;
  } blend_cfg_t;

  typedef struct packed {
    pixel_t background_pixel;
    byte_t  osd_value;
    byte_t  alpha_weight;
    logic   end_of_region;
  } blend_req_t;

endpackage

// ----- hdl/osd_alpha_blend_rgb15_rgb16_core.sv -----
`timescale 1ns / 1ps

// Channel   Valid           Stall           Payload
// pixel     pixel_valid     pixel_stall     background_pixel, osd_value, alpha_weight,
//                                           end_of_region
// result    result_valid    result_stall    blended_pixel, last_pixel
// config    cfg_write       (none)          cfg_index, cfg_data
//
// One pixel request is accepted per cycle while pixel_stall is low; each one passes
// through an input register and a result register with three 6x8 multipliers between.
// Reset clears both valid flags and sets the format to 5:6:5 with fast mode off.
// A stall on the result side holds a full result register and, if the input register is
// also full, stalls the pixel side in the same cycle.

module osd_alpha_blend_rgb15_rgb16_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  osdab_pkg::pixel_t background_pixel,
  input  osdab_pkg::byte_t  osd_value,
  input  osdab_pkg::byte_t  alpha_weight,
  input  logic             end_of_region,
  output logic             result_valid,
  input  logic             result_stall,
  output osdab_pkg::pixel_t blended_pixel,
  output logic             last_pixel,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic             cfg_data
);
  import osdab_pkg::*;

  blend_cfg_t cfg;
  blend_req_t req;
  logic       req_valid;
  logic       result_load;
  pixel_t     blended_next;

  assign result_load = !result_valid || !result_stall;
  assign pixel_stall = req_valid && !result_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= FMT_RGB565;
      cfg.fast_mode    <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_PIXEL_FORMAT: cfg.pixel_format <= pixel_format_t'(cfg_data);
        REG_FAST_MODE:    cfg.fast_mode    <= cfg_data;
        default:          cfg              <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!pixel_stall) begin
      req_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && !pixel_stall) begin
      req.background_pixel <= background_pixel;
      req.osd_value        <= osd_value;
      req.alpha_weight     <= alpha_weight;
      req.end_of_region    <= end_of_region;
    end
  end

  osdab_calc u_calc (
    .cfg     (cfg),
    .req     (req),
    .blended (blended_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load && req_valid) begin
      blended_pixel <= blended_next;
      last_pixel    <= req.end_of_region;
    end
  end

endmodule

// ----- hdl/osdab_chan.sv -----
`timescale 1ns / 1ps

module osdab_chan (
  input  osdab_pkg::chan_t chan,
  input  logic             wide,
  input  osdab_pkg::byte_t weight,
  input  osdab_pkg::byte_t osd_value,
  output osdab_pkg::chan_t result
);
  import osdab_pkg::*;

  logic [13:0] product;
  logic [8:0]  scaled;
  logic [9:0]  sum;
  logic [7:0]  narrowed;
  chan_t       limit;

  always_comb begin
    product  = 14'(chan) * 14'(weight);
    scaled   = wide ? {1'b0, product[13:6]} : product[13:5];
    sum      = 10'(scaled) + 10'(osd_value);
    narrowed = wide ? sum[9:2] : {1'b0, sum[9:3]};
    limit    = wide ? CH6_MAX : CH5_MAX;
    result   = (narrowed > 8'(limit)) ? limit : narrowed[ChanWidth-1:0];
  end

endmodule

// ----- hdl/osdab_calc.sv -----
`timescale 1ns / 1ps

module osdab_calc (
  input  osdab_pkg::blend_cfg_t cfg,
  input  osdab_pkg::blend_req_t req,
  output osdab_pkg::pixel_t     blended
);
  import osdab_pkg::*;

  logic  wide;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  logic [4:0] grey5;
  pixel_t pix;

  assign pix      = req.background_pixel;
  assign wide     = (cfg.pixel_format == FMT_RGB565);
  assign red_in   = {1'b0, pix[4:0]};
  assign green_in = wide ? pix[10:5] : {1'b0, pix[9:5]};
  assign blue_in  = wide ? {1'b0, pix[15:11]} : {1'b0, pix[14:10]};
  assign grey5    = req.osd_value[7:3];

  osdab_chan u_red (
    .chan      (red_in),
    .wide      (1'b0),
    .weight    (req.alpha_weight),
    .osd_value (req.osd_value),
    .result    (red_out)
  );

  osdab_chan u_green (
    .chan      (green_in),
    .wide      (wide),
    .weight    (req.alpha_weight),
    .osd_value (req.osd_value),
    .result    (green_out)
  );

  osdab_chan u_blue (
    .chan      (blue_in),
    .wide      (1'b0),
    .weight    (req.alpha_weight),
    .osd_value (req.osd_value),
    .result    (blue_out)
  );

  always_comb begin
    if (req.alpha_weight == '0) begin
      blended = pix;
    end else if (cfg.fast_mode) begin
      if (wide) begin
        blended = {grey5, req.osd_value[7:2], grey5};
      end else begin
        blended = {1'b0, grey5, grey5, grey5};
      end
    end else if (wide) begin
      blended = {blue_out[4:0], green_out, red_out[4:0]};
    end else begin
      blended = {1'b0, blue_out[4:0], green_out[4:0], red_out[4:0]};
    end
  end

endmodule
